FILE: rtl/cpar_pkg.sv
// shared types, widths and helper functions for closest_point_on_axis_to_ray
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package cpar_pkg;

	localparam int W = 32;
	localparam int DOT_W = 66;
	localparam int MAG_W = 65;
	localparam int DEN_W = 128;
	localparam int NUM_W = 131;
	localparam int NMAG_W = 130;
	localparam int PROD_W = 161;
	localparam int REM_W = 163;
	localparam int DV_W = 129;
	localparam int QB = 33;
	localparam int QS_W = 35;
	localparam int DIV_NST = QB + 1;

	localparam int LIMB_W = 32;
	localparam int MA_LIMBS = 5;
	localparam int MB_LIMBS = 3;
	localparam int MA_W = LIMB_W * MA_LIMBS;
	localparam int MB_W = LIMB_W * MB_LIMBS;
	localparam int ROW_W = LIMB_W + MB_W;
	localparam int MP_W = 256;
	localparam int MUL_LAT = 3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_PARALLEL = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	typedef struct packed {
		logic signed [W-1:0] ray_pos_x;
		logic signed [W-1:0] ray_pos_y;
		logic signed [W-1:0] ray_pos_z;
		logic signed [W-1:0] ray_dir_x;
		logic signed [W-1:0] ray_dir_y;
		logic signed [W-1:0] ray_dir_z;
		logic signed [W-1:0] axis_pos_x;
		logic signed [W-1:0] axis_pos_y;
		logic signed [W-1:0] axis_pos_z;
		logic signed [W-1:0] axis_dir_x;
		logic signed [W-1:0] axis_dir_y;
		logic signed [W-1:0] axis_dir_z;
	} cpar_in_t;

	typedef struct packed {
		logic signed [W-1:0] near_x;
		logic signed [W-1:0] near_y;
		logic signed [W-1:0] near_z;
		logic [1:0] status;
	} cpar_out_t;

	typedef struct packed {
		logic sbe;
		logic sf;
		logic [2:0][W-1:0] p2;
		logic [2:0][W-1:0] d2;
	} side1_t;

	typedef struct packed {
		logic [DEN_W-1:0] den;
		logic parallel;
		logic [2:0] sgn;
		logic [2:0][W-1:0] p2;
	} side2_t;

	typedef struct packed {
		logic parallel;
		logic [DV_W-1:0] dv;
		logic [2:0][REM_W-1:0] rem;
		logic [2:0][QB-1:0] quo;
		logic [2:0] ovf;
		logic [2:0] neg;
		logic [2:0][W-1:0] p2;
	} cpar_div_t;

	function automatic cpar_div_t div_first(input cpar_div_t x);
		cpar_div_t r;
		logic [REM_W-1:0] lim;
		r = x;
		lim = REM_W'(x.dv) << QB;
		for (int l = 0; l < 3; l++) begin
			r.ovf[l] = (x.rem[l] >= lim);
			r.quo[l] = '0;
		end
		return r;
	endfunction

	function automatic cpar_div_t div_step(input cpar_div_t x, input int sh);
		cpar_div_t r;
		logic [REM_W-1:0] dsh;
		r = x;
		dsh = REM_W'(x.dv) << sh;
		for (int l = 0; l < 3; l++) begin
			if (x.rem[l] >= dsh) begin
				r.rem[l] = x.rem[l] - dsh;
				r.quo[l] = x.quo[l] | (QB'(1) << sh);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/cpar_mulu.sv
// unsigned limb multiplier, three register stages: partial products, rows, total
// depends on cpar_pkg
`timescale 1ns / 1ps
`default_nettype none

module cpar_mulu (
	input  wire logic clk,
	input  wire logic en,
	input  wire logic [cpar_pkg::MA_W-1:0] a,
	input  wire logic [cpar_pkg::MB_W-1:0] b,
	output logic [cpar_pkg::MP_W-1:0] p
);

	logic [2*cpar_pkg::LIMB_W-1:0] pp_s1 [cpar_pkg::MA_LIMBS][cpar_pkg::MB_LIMBS];
	logic [cpar_pkg::ROW_W-1:0] row_s2 [cpar_pkg::MA_LIMBS];
	logic [cpar_pkg::ROW_W-1:0] row_n [cpar_pkg::MA_LIMBS];
	logic [cpar_pkg::MP_W-1:0] p_s3;
	logic [cpar_pkg::MP_W-1:0] p_n;

	always_comb begin
		for (int i = 0; i < cpar_pkg::MA_LIMBS; i++) begin
			row_n[i] = '0;
			for (int j = 0; j < cpar_pkg::MB_LIMBS; j++) begin
				row_n[i] = row_n[i]
					+ (cpar_pkg::ROW_W'(pp_s1[i][j]) << (cpar_pkg::LIMB_W * j));
			end
		end
		p_n = '0;
		for (int i = 0; i < cpar_pkg::MA_LIMBS; i++) begin
			p_n = p_n + (cpar_pkg::MP_W'(row_s2[i]) << (cpar_pkg::LIMB_W * i));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < cpar_pkg::MA_LIMBS; i++) begin
				for (int j = 0; j < cpar_pkg::MB_LIMBS; j++) begin
					pp_s1[i][j] <= a[i*cpar_pkg::LIMB_W +: cpar_pkg::LIMB_W]
						* b[j*cpar_pkg::LIMB_W +: cpar_pkg::LIMB_W];
				end
			end
			row_s2 <= row_n;
			p_s3 <= p_n;
		end
	end

	assign p = p_s3;

endmodule

`default_nettype wire

FILE: rtl/cpar_div.sv
// pipelined restoring divider, three lanes sharing one divisor: an overflow check stage, then one quotient bit a stage
// depends on cpar_pkg
`timescale 1ns / 1ps
`default_nettype none

module cpar_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic din_valid,
	input  wire cpar_pkg::cpar_div_t din,
	output logic dout_valid,
	output cpar_pkg::cpar_div_t dout
);

	logic [cpar_pkg::DIV_NST-1:0] vld_s;
	cpar_pkg::cpar_div_t dat_s [cpar_pkg::DIV_NST];
	cpar_pkg::cpar_div_t nxt [cpar_pkg::DIV_NST];

	always_comb begin
		nxt[0] = cpar_pkg::div_first(din);
		for (int i = 1; i < cpar_pkg::DIV_NST; i++) begin
			nxt[i] = cpar_pkg::div_step(dat_s[i-1], cpar_pkg::QB - i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[cpar_pkg::DIV_NST-2:0], din_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_s <= nxt;
		end
	end

	assign dout_valid = vld_s[cpar_pkg::DIV_NST-1];
	assign dout = dat_s[cpar_pkg::DIV_NST-1];

endmodule

`default_nettype wire

FILE: rtl/closest_point_on_axis_to_ray.sv
// closest point on an axis line to a ray: top level pipeline and output register
// depends on cpar_pkg, cpar_mulu, cpar_div
//
// usage:
//   input channel item/item_valid/item_stall carries one ray (origin, direction) and one
//   axis line (point, direction), all signed Q16.16. output channel res/res_valid/res_stall
//   returns the point on the axis nearest the ray and a status (ok, parallel, saturated).
//   one result per transaction, in order.
//   throughput: one transaction per cycle while item_stall is low. each one passes three
//   dot-product stages, two three-stage limb multipliers with their glue stages, a 34-stage
//   divider (overflow check, then one quotient bit per stage) and the output register.
//   a parallel or degenerate pair returns the axis point with status parallel.
//   reset clears every valid bit; nothing else needs clearing.
//   when res_stall holds a result, the pipeline keeps advancing and taking new transactions
//   until a finished result reaches its last stage; only then is item_stall raised.
`timescale 1ns / 1ps
`default_nettype none

module closest_point_on_axis_to_ray (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	output logic item_stall,
	input  wire cpar_pkg::cpar_in_t item,
	output logic res_valid,
	input  wire logic res_stall,
	output cpar_pkg::cpar_out_t res
);

	localparam int W = cpar_pkg::W;
	localparam int DOT_W = cpar_pkg::DOT_W;
	localparam int MAG_W = cpar_pkg::MAG_W;
	localparam int DEN_W = cpar_pkg::DEN_W;
	localparam int NUM_W = cpar_pkg::NUM_W;
	localparam int NMAG_W = cpar_pkg::NMAG_W;
	localparam int PROD_W = cpar_pkg::PROD_W;
	localparam int REM_W = cpar_pkg::REM_W;
	localparam int QS_W = cpar_pkg::QS_W;
	localparam int MUL_LAT = cpar_pkg::MUL_LAT;

	logic en;
	logic div_vld;
	cpar_pkg::cpar_div_t div_out;

	assign en = !(div_vld && res_valid && res_stall);
	assign item_stall = !en;

	// input unpacking
	logic signed [W-1:0] p1 [3];
	logic signed [W-1:0] d1 [3];
	logic signed [W-1:0] p2 [3];
	logic signed [W-1:0] d2 [3];
	logic signed [W:0] v [3];

	always_comb begin
		p1[0] = item.ray_pos_x;
		p1[1] = item.ray_pos_y;
		p1[2] = item.ray_pos_z;
		d1[0] = item.ray_dir_x;
		d1[1] = item.ray_dir_y;
		d1[2] = item.ray_dir_z;
		p2[0] = item.axis_pos_x;
		p2[1] = item.axis_pos_y;
		p2[2] = item.axis_pos_z;
		d2[0] = item.axis_dir_x;
		d2[1] = item.axis_dir_y;
		d2[2] = item.axis_dir_z;
		for (int k = 0; k < 3; k++) begin
			v[k] = (W+1)'(p2[k]) - (W+1)'(p1[k]);
		end
	end

	// stage 1: element products of the five dot products
	logic v_s1, v_s2, v_s3, v_s7, v_s8, v_s12;
	logic signed [DOT_W-1:0] pa_s1 [3];
	logic signed [DOT_W-1:0] pb_s1 [3];
	logic signed [DOT_W-1:0] pc_s1 [3];
	logic signed [DOT_W-1:0] pe_s1 [3];
	logic signed [DOT_W-1:0] pf_s1 [3];
	logic [2:0][W-1:0] p2_s1, d2_s1, p2_s2, d2_s2;

	// stage 2: dot products
	logic signed [DOT_W-1:0] a_s2, b_s2, c_s2, e_s2, f_s2;

	// stage 3: magnitudes and signs
	logic [MAG_W-1:0] ma_s3, mb_s3, mc_s3, me_s3, mf_s3;
	cpar_pkg::side1_t sd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pa_s1[k] <= DOT_W'(d1[k]) * DOT_W'(d1[k]);
				pb_s1[k] <= DOT_W'(d1[k]) * DOT_W'(d2[k]);
				pc_s1[k] <= DOT_W'(d2[k]) * DOT_W'(d2[k]);
				pe_s1[k] <= DOT_W'(d1[k]) * DOT_W'(v[k]);
				pf_s1[k] <= DOT_W'(d2[k]) * DOT_W'(v[k]);
				p2_s1[k] <= p2[k];
				d2_s1[k] <= d2[k];
			end
			a_s2 <= pa_s1[0] + pa_s1[1] + pa_s1[2];
			b_s2 <= pb_s1[0] + pb_s1[1] + pb_s1[2];
			c_s2 <= pc_s1[0] + pc_s1[1] + pc_s1[2];
			e_s2 <= pe_s1[0] + pe_s1[1] + pe_s1[2];
			f_s2 <= pf_s1[0] + pf_s1[1] + pf_s1[2];
			p2_s2 <= p2_s1;
			d2_s2 <= d2_s1;
			ma_s3 <= MAG_W'(a_s2);
			mc_s3 <= MAG_W'(c_s2);
			mb_s3 <= b_s2[DOT_W-1] ? MAG_W'(-b_s2) : MAG_W'(b_s2);
			me_s3 <= e_s2[DOT_W-1] ? MAG_W'(-e_s2) : MAG_W'(e_s2);
			mf_s3 <= f_s2[DOT_W-1] ? MAG_W'(-f_s2) : MAG_W'(f_s2);
			sd_s3.sbe <= b_s2[DOT_W-1] ^ e_s2[DOT_W-1];
			sd_s3.sf <= f_s2[DOT_W-1];
			sd_s3.p2 <= p2_s2;
			sd_s3.d2 <= d2_s2;
		end
	end

	// stages 4 to 6: den and num products
	logic [cpar_pkg::MP_W-1:0] p_ac, p_bb, p_be, p_af;

	cpar_mulu u_mul_ac (.clk(clk), .en(en), .a(cpar_pkg::MA_W'(ma_s3)),
		.b(cpar_pkg::MB_W'(mc_s3)), .p(p_ac));
	cpar_mulu u_mul_bb (.clk(clk), .en(en), .a(cpar_pkg::MA_W'(mb_s3)),
		.b(cpar_pkg::MB_W'(mb_s3)), .p(p_bb));
	cpar_mulu u_mul_be (.clk(clk), .en(en), .a(cpar_pkg::MA_W'(mb_s3)),
		.b(cpar_pkg::MB_W'(me_s3)), .p(p_be));
	cpar_mulu u_mul_af (.clk(clk), .en(en), .a(cpar_pkg::MA_W'(ma_s3)),
		.b(cpar_pkg::MB_W'(mf_s3)), .p(p_af));

	logic [MUL_LAT-1:0] vm1_s;
	cpar_pkg::side1_t sd1_s [MUL_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vm1_s <= '0;
		end else if (en) begin
			vm1_s <= {vm1_s[MUL_LAT-2:0], v_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd1_s[0] <= sd_s3;
			for (int i = 1; i < MUL_LAT; i++) begin
				sd1_s[i] <= sd1_s[i-1];
			end
		end
	end

	// stage 7: den = |d1|^2 |d2|^2 - (d1.d2)^2, num = (d1.d2)(d1.v) - |d1|^2 (d2.v)
	cpar_pkg::side1_t sl1;
	logic signed [NUM_W-1:0] tbe, taf;
	logic [DEN_W-1:0] den_s7;
	logic signed [NUM_W-1:0] num_s7;
	logic [2:0][W-1:0] p2_s7, d2_s7;

	assign sl1 = sd1_s[MUL_LAT-1];

	always_comb begin
		tbe = NUM_W'(p_be[NMAG_W-1:0]);
		taf = NUM_W'(p_af[NMAG_W-1:0]);
		if (sl1.sbe) begin
			tbe = -tbe;
		end
		if (sl1.sf) begin
			taf = -taf;
		end
	end

	// stage 8: magnitudes for the per-axis products
	logic [NMAG_W-1:0] nmag_s8;
	logic [2:0][W-1:0] dmag_s8;
	cpar_pkg::side2_t sd_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s7 <= vm1_s[MUL_LAT-1];
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s7 <= p_ac[DEN_W-1:0] - p_bb[DEN_W-1:0];
			num_s7 <= tbe - taf;
			p2_s7 <= sl1.p2;
			d2_s7 <= sl1.d2;
			nmag_s8 <= num_s7[NUM_W-1] ? NMAG_W'(-num_s7) : NMAG_W'(num_s7);
			sd_s8.den <= den_s7;
			sd_s8.parallel <= (den_s7 == '0);
			sd_s8.p2 <= p2_s7;
			for (int k = 0; k < 3; k++) begin
				dmag_s8[k] <= d2_s7[k][W-1] ? W'(-d2_s7[k]) : d2_s7[k];
				sd_s8.sgn[k] <= num_s7[NUM_W-1] ^ d2_s7[k][W-1];
			end
		end
	end

	// stages 9 to 11: d2k * num
	logic [cpar_pkg::MP_W-1:0] p_prod [3];

	for (genvar k = 0; k < 3; k++) begin : g_prod
		cpar_mulu u_mul_p (.clk(clk), .en(en), .a(cpar_pkg::MA_W'(nmag_s8)),
			.b(cpar_pkg::MB_W'(dmag_s8[k])), .p(p_prod[k]));
	end

	logic [MUL_LAT-1:0] vm2_s;
	cpar_pkg::side2_t sd2_s [MUL_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vm2_s <= '0;
		end else if (en) begin
			vm2_s <= {vm2_s[MUL_LAT-2:0], v_s8};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd2_s[0] <= sd_s8;
			for (int i = 1; i < MUL_LAT; i++) begin
				sd2_s[i] <= sd2_s[i-1];
			end
		end
	end

	// stage 12: rounded dividend 2|prod| + den over divisor 2 den
	cpar_pkg::side2_t sl2;
	cpar_pkg::cpar_div_t dn_s12;

	assign sl2 = sd2_s[MUL_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s12 <= vm2_s[MUL_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dn_s12.parallel <= sl2.parallel;
			dn_s12.dv <= {sl2.den, 1'b0};
			dn_s12.ovf <= '0;
			dn_s12.neg <= sl2.sgn;
			dn_s12.p2 <= sl2.p2;
			for (int k = 0; k < 3; k++) begin
				dn_s12.rem[k] <= REM_W'({p_prod[k][PROD_W-1:0], 1'b0}) + REM_W'(sl2.den);
				dn_s12.quo[k] <= '0;
			end
		end
	end

	cpar_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.din_valid(v_s12),
		.din(dn_s12),
		.dout_valid(div_vld),
		.dout(div_out)
	);

	// final add, saturation and status
	logic [2:0][W-1:0] near;
	logic [2:0] sat;
	logic signed [QS_W-1:0] qs [3];
	logic signed [QS_W-1:0] sum [3];
	cpar_pkg::cpar_out_t res_n;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qs[k] = QS_W'(div_out.quo[k]);
			if (div_out.neg[k]) begin
				qs[k] = -qs[k];
			end
			sum[k] = QS_W'($signed(div_out.p2[k])) + qs[k];
			sat[k] = 1'b0;
			near[k] = sum[k][W-1:0];
			if (div_out.parallel) begin
				near[k] = div_out.p2[k];
			end else if (div_out.ovf[k]) begin
				sat[k] = 1'b1;
				near[k] = div_out.neg[k] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			end else if (sum[k][QS_W-1:W-1] != {(QS_W-W+1){sum[k][QS_W-1]}}) begin
				sat[k] = 1'b1;
				near[k] = sum[k][QS_W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			end
		end
		res_n.near_x = near[0];
		res_n.near_y = near[1];
		res_n.near_z = near[2];
		if (div_out.parallel) begin
			res_n.status = cpar_pkg::ST_PARALLEL;
		end else if (sat != 3'b000) begin
			res_n.status = cpar_pkg::ST_SAT;
		end else begin
			res_n.status = cpar_pkg::ST_OK;
		end
	end

	// output register
	cpar_pkg::cpar_out_t res_q;
	logic res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || !res_stall) begin
			res_valid_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (!res_valid_q || !res_stall) begin
			res_q <= res_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

`default_nettype wire
